// ----- rtl/core/kmdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdr_pkg
// Shared constants and types of the keyed median deadband reporter.
// ----------------------------------------------------------------------------
package kmdr_pkg;

  localparam int unsigned TableEntries  = 64;
  localparam int unsigned WinSamples    = 10;
  localparam int unsigned SlotW         = $clog2(TableEntries);
  localparam int unsigned FillW         = $clog2(WinSamples + 1);
  localparam int unsigned WinIdxW       = (WinSamples > 1) ? $clog2(WinSamples) : 1;
  localparam int unsigned SampDepth     = TableEntries * WinSamples;
  localparam int unsigned SampAddrW     = $clog2(SampDepth);
  localparam logic [31:0] DefIntervalMs = 32'd60000;

  typedef enum logic [2:0] {
    OUT_STORED    = 3'd0,
    OUT_NO_CHANGE = 3'd1,
    OUT_RATE_LIM  = 3'd2,
    OUT_REPORTED  = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_ADDR_ZERO = 3'd5
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_UPDATE,
    ST_LOAD,
    ST_SORT,
    ST_DECIDE,
    ST_DONE
  } state_e;

  // one table entry: key, kind, deadband and per-metric state
  typedef struct packed {
    logic [15:0]        svc;
    logic [7:0]         addr;
    logic [7:0]         met;
    logic               kind;
    logic [30:0]        thr;
    logic [FillW-1:0]   fill;
    logic               pvalid;
    logic signed [31:0] pval;
    logic [31:0]        ptime;
  } entry_t;

  typedef struct packed {
    outcome_e           outcome;
    logic               report;
    logic signed [31:0] window;
    logic [5:0]         slot;
  } result_t;

endpackage

// ----- rtl/core/keyed_median_deadband_reporter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_median_deadband_reporter
// Keyed metric table with per-metric sample window, median and deadband report.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word: tdata holds the key, sample, threshold
//   and time stamp, tuser the metric kind. m_axis returns one result word per
//   sample word. cfg_we_i/cfg_wdata_i load the minimum upload interval.
//   One word is worked on at a time. The key search reads the entry RAM one
//   entry at a time, read in ST_SCAN_RD and compared in ST_SCAN_CMP; a
//   completed analog window adds a load of its samples from the sample RAM
//   and 10 sort passes. Reset clears all entry valid flags and loads the
//   interval with 60000; no clearing pass is needed. A result waits in the
//   output register while m_axis_tready is low; the next sample is taken
//   only after it leaves.
// ----------------------------------------------------------------------------
module keyed_median_deadband_reporter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // service_code, device_address, metric_number, sample_value,
  // change_threshold, time_ms, zero pad
  input  logic [127:0] s_axis_tdata,
  // metric_kind
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // outcome, report_now, window_result, slot_used, zero pad
  output logic [47:0]  m_axis_tdata
);
  import kmdr_pkg::*;

  state_e  state_q, state_d;
  logic [31:0] interval_q;
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [SlotW-1:0] idx_q, idx_d, slot_q, slot_d, free_q, free_d;
  logic free_seen_q, free_seen_d;
  entry_t ent_q, ent_d, ent_rdata;
  logic [15:0] svc_q, svc_d;
  logic [7:0]  addr_q, addr_d, met_q, met_d;
  logic        kind_q, kind_d;
  logic signed [31:0] samp_q, samp_d;
  logic [30:0] thr_q, thr_d;
  logic [31:0] time_q, time_d;
  logic signed [31:0] win_q [WinSamples];
  logic signed [31:0] win_d [WinSamples];
  logic [FillW-1:0] cnt_q, cnt_d;
  logic signed [31:0] res_win_q, res_win_d;
  result_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic ent_we;
  logic [SlotW-1:0] ent_raddr;
  entry_t ent_wdata;
  logic samp_we;
  logic [SampAddrW-1:0] samp_waddr, samp_raddr, slot_base;
  logic [31:0] samp_rdata;

  logic signed [32:0] med_sum, diff, adiff;
  logic signed [31:0] median;
  logic [FillW-1:0] fill_new;
  logic changed, limited;

  kmdr_ram #(.Width($bits(entry_t)), .Depth(TableEntries)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(slot_q), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  kmdr_ram #(.Width(32), .Depth(SampDepth)) u_samp_ram (
    .clk_i, .we_i(samp_we), .waddr_i(samp_waddr), .wdata_i(samp_q),
    .raddr_i(samp_raddr), .rdata_o(samp_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.slot, out_q.window, out_q.report, out_q.outcome};

  assign slot_base  = SampAddrW'(slot_q * WinSamples);
  assign samp_waddr = slot_base + SampAddrW'(ent_q.fill);
  assign samp_raddr = slot_base + SampAddrW'(cnt_q);
  assign fill_new   = ent_q.fill + 1'b1;

  // median; mean of the two middle values truncated toward zero when even
  always_comb begin
    med_sum = 33'sd0;
    if ((WinSamples % 2) == 0) begin
      med_sum = 33'(win_q[WinSamples/2-1]) + 33'(win_q[WinSamples/2]);
      med_sum = med_sum + 33'(med_sum[32]);
      median  = 32'(med_sum >>> 1);
    end else begin
      median  = win_q[WinSamples/2];
    end
  end

  always_comb begin
    diff    = 33'(res_win_q) - 33'(ent_q.pval);
    adiff   = diff[32] ? -diff : diff;
    if (!ent_q.pvalid) begin
      changed = 1'b1;
    end else if (ent_q.kind) begin
      changed = (res_win_q != ent_q.pval);
    end else begin
      changed = (adiff >= $signed({2'b00, ent_q.thr}));
    end
    limited = ent_q.pvalid && ((time_q - ent_q.ptime) < interval_q);
  end

  always_comb begin
    state_d = state_q; valid_d = valid_q; idx_d = idx_q; slot_d = slot_q;
    free_d = free_q; free_seen_d = free_seen_q; ent_d = ent_q;
    svc_d = svc_q; addr_d = addr_q; met_d = met_q; kind_d = kind_q;
    samp_d = samp_q; thr_d = thr_q; time_d = time_q;
    win_d = win_q; cnt_d = cnt_q; res_win_d = res_win_q;
    out_d = out_q; out_valid_d = out_valid_q;
    ent_we = 1'b0; ent_raddr = idx_q; ent_wdata = ent_q; samp_we = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          svc_d  = s_axis_tdata[15:0];
          addr_d = s_axis_tdata[23:16];
          met_d  = s_axis_tdata[31:24];
          samp_d = s_axis_tdata[63:32];
          thr_d  = s_axis_tdata[94:64];
          time_d = s_axis_tdata[126:95];
          kind_d = s_axis_tuser[0];
          idx_d = '0; free_seen_d = 1'b0;
          out_d = '{outcome: OUT_ADDR_ZERO, report: 1'b0, window: '0, slot: '0};
          state_d = (s_axis_tdata[23:16] == 8'd0) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (valid_q[idx_q] && ent_rdata.svc == svc_q && ent_rdata.addr == addr_q
            && ent_rdata.met == met_q) begin
          slot_d = idx_q; ent_d = ent_rdata; state_d = ST_UPDATE;
        end else begin
          if (!valid_q[idx_q] && !free_seen_q) begin
            free_seen_d = 1'b1; free_d = idx_q;
          end
          if (32'(idx_q) == TableEntries - 1) begin
            if (free_seen_d) begin
              slot_d = free_d;
              valid_d[free_d] = 1'b1;
              ent_d = '{svc: svc_q, addr: addr_q, met: met_q, kind: kind_q, thr: thr_q,
                        fill: '0, pvalid: 1'b0, pval: '0, ptime: '0};
              state_d = ST_UPDATE;
            end else begin
              out_d = '{outcome: OUT_FULL, report: 1'b0, window: '0, slot: '0};
              state_d = ST_DONE;
            end
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_UPDATE: begin
        samp_we = 1'b1;
        out_d.slot = 6'(slot_q);
        if (32'(fill_new) < WinSamples) begin
          ent_d.fill = fill_new;
          ent_we = 1'b1; ent_wdata = ent_d;
          out_d.outcome = OUT_STORED; out_d.report = 1'b0; out_d.window = '0;
          state_d = ST_DONE;
        end else if (ent_q.kind) begin
          res_win_d = samp_q;
          state_d = ST_DECIDE;
        end else begin
          cnt_d = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // read pipelined: address cnt, data of cnt-1 arrives now
        if (cnt_q != '0) begin
          win_d[WinIdxW'(cnt_q - 1'b1)] = samp_rdata;
        end
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == WinSamples) begin
          cnt_d = '0;
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        // odd-even transposition sort, one pass per cycle
        for (int k = 0; k + 1 < WinSamples; k++) begin
          if ((k % 2) == int'(cnt_q[0]) && win_q[k] > win_q[k+1]) begin
            win_d[k]   = win_q[k+1];
            win_d[k+1] = win_q[k];
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == WinSamples - 1) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!ent_q.kind && 32'(cnt_q) == WinSamples) begin
          // first cycle after sort: capture the median
          res_win_d = median;
          cnt_d = '0;
        end else begin
          ent_d.fill = '0;
          out_d.window = res_win_q;
          out_d.report = 1'b0;
          if (!changed) begin
            out_d.outcome = OUT_NO_CHANGE;
          end else if (limited) begin
            out_d.outcome = OUT_RATE_LIM;
          end else begin
            out_d.outcome = OUT_REPORTED;
            out_d.report = 1'b1;
            ent_d.pvalid = 1'b1; ent_d.pval = res_win_q; ent_d.ptime = time_q;
          end
          ent_we = 1'b1; ent_wdata = ent_d;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      interval_q <= DefIntervalMs;
      valid_q <= '0;
      out_valid_q <= 1'b0;
      free_seen_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      valid_q <= valid_d;
      out_valid_q <= out_valid_d;
      free_seen_q <= free_seen_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d; free_q <= free_d; ent_q <= ent_d;
    svc_q <= svc_d; addr_q <= addr_d; met_q <= met_d; kind_q <= kind_d;
    samp_q <= samp_d; thr_q <= thr_d; time_q <= time_d;
    win_q <= win_d; res_win_q <= res_win_d; out_q <= out_d;
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  a_report_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.report == (out_q.outcome == OUT_REPORTED)))
    else $error("report flag disagrees with outcome");

  a_reject_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.outcome == OUT_FULL || out_q.outcome == OUT_ADDR_ZERO))
    |-> (out_q.slot == '0 && out_q.window == '0))
    else $error("rejected word carries slot or value");

endmodule

// ----- rtl/core/kmdr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdr_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmdr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sim/kmdr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdr_checker
// Watches both streams of the reporter, predicts each result from a private
// copy of the metric table and compares it field by field.
// ----------------------------------------------------------------------------
module kmdr_checker
  import kmdr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending_count
);

  typedef struct {
    bit                valid;
    bit [15:0]         svc;
    bit [7:0]          addr;
    bit [7:0]          met;
    bit                kind;
    bit [30:0]         thr;
    int                win[WinSamples];
    int unsigned       fill;
    bit                pvalid;
    int                pval;
    bit [31:0]         ptime;
  } metric_t;

  metric_t     metrics[TableEntries];
  bit   [31:0] interval_ms;
  result_t     expected_q[$];

  function automatic int window_median(int w[WinSamples]);
    int          s[WinSamples];
    int          t;
    longint      sum;
    s = w;
    for (int i = 1; i < WinSamples; i++)
      for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
        t = s[j]; s[j] = s[j-1]; s[j-1] = t;
      end
    if (WinSamples % 2 == 0) begin
      sum = longint'(s[WinSamples/2-1]) + longint'(s[WinSamples/2]);
      return int'(sum / 2);
    end
    return s[WinSamples/2];
  endfunction

  function automatic result_t predict_outcome(logic [127:0] d, logic kind);
    result_t     r;
    bit [15:0]   svc;
    bit [7:0]    addr;
    bit [7:0]    met;
    int          smp;
    bit [30:0]   thr;
    bit [31:0]   now;
    int          hit;
    int          free;
    int          k;
    int          val;
    longint      diff;
    bit          changed;
    svc  = d[15:0];
    addr = d[23:16];
    met  = d[31:24];
    smp  = d[63:32];
    thr  = d[94:64];
    now  = d[126:95];
    r = '{outcome: OUT_STORED, report: 1'b0, window: '0, slot: '0};
    if (addr == 0) begin
      r.outcome = OUT_ADDR_ZERO;
      return r;
    end
    hit = -1;
    free = -1;
    for (int i = 0; i < TableEntries; i++)
      if (metrics[i].valid) begin
        if (hit < 0 && metrics[i].svc == svc && metrics[i].addr == addr &&
            metrics[i].met == met)
          hit = i;
      end else if (free < 0) begin
        free = i;
      end
    if (hit < 0) begin
      if (free < 0) begin
        r.outcome = OUT_FULL;
        return r;
      end
      hit = free;
      metrics[hit].valid = 1;
      metrics[hit].svc = svc;
      metrics[hit].addr = addr;
      metrics[hit].met = met;
      metrics[hit].kind = kind;
      metrics[hit].thr = thr;
      metrics[hit].fill = 0;
      metrics[hit].pvalid = 0;
      metrics[hit].pval = 0;
      metrics[hit].ptime = 0;
    end
    k = hit;
    r.slot = 6'(k);
    metrics[k].win[metrics[k].fill] = smp;
    metrics[k].fill++;
    if (metrics[k].fill < WinSamples) return r;
    val = metrics[k].kind ? smp : window_median(metrics[k].win);
    metrics[k].fill = 0;
    if (!metrics[k].pvalid) begin
      changed = 1;
    end else if (metrics[k].kind) begin
      changed = val != metrics[k].pval;
    end else begin
      diff = longint'(val) - longint'(metrics[k].pval);
      if (diff < 0) diff = -diff;
      changed = diff >= longint'(metrics[k].thr);
    end
    if (!changed) begin
      r.outcome = OUT_NO_CHANGE;
    end else if (metrics[k].pvalid && (now - metrics[k].ptime) < interval_ms) begin
      r.outcome = OUT_RATE_LIM;
    end else begin
      r.outcome = OUT_REPORTED;
      r.report = 1;
      metrics[k].pvalid = 1;
      metrics[k].pval = val;
      metrics[k].ptime = now;
    end
    r.window = val;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      interval_ms = DefIntervalMs;
      for (int i = 0; i < TableEntries; i++) metrics[i].valid = 0;
      expected_q.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_we_i) interval_ms = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_outcome(s_axis_tdata, s_axis_tuser[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{outcome: outcome_e'(m_axis_tdata[2:0]), report: m_axis_tdata[3],
                window: m_axis_tdata[35:4], slot: m_axis_tdata[41:36]};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got.outcome !== want.outcome || got.report !== want.report ||
              got.window !== want.window || got.slot !== want.slot) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("result mismatch: exp out=%0d rep=%0d win=%0d slot=%0d, ",
                     want.outcome, want.report, want.window, want.slot);
              $display("got out=%0d rep=%0d win=%0d slot=%0d",
                       got.outcome, got.report, got.window, got.slot);
            end
          end
        end
      end
      pending_count = expected_q.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample words into the reporter with random gaps and stalls; a
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import kmdr_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [47:0]  m_axis_tdata;
  int           fail_count;
  int           pending_count;
  bit           stall_long;

  always #10 clk_i = ~clk_i;

  keyed_median_deadband_reporter uut (.*);
  kmdr_checker checker_i (.*);

  // key pool kept small so windows complete often
  bit [15:0] pool_svc[8];
  bit [7:0]  pool_addr[8];
  bit [7:0]  pool_met[8];
  bit [31:0] tick;

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // tvalid stays high between back-to-back words; it drops only before a gap
  task automatic send_sample(bit [15:0] svc, bit [7:0] addr, bit [7:0] met, bit kind,
                             bit [31:0] smp, bit [30:0] thr, bit [31:0] now);
    int unsigned g;
    g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {1'b0, now, thr, smp, met, addr, svc};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic drain_and_config(bit [31:0] value);
    wait_drained();
    repeat (200) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 0;
  endtask

  // one well-formed window of samples for a known key
  task automatic send_window(int p, bit kind, int base, int spread, bit [30:0] thr);
    for (int i = 0; i < WinSamples; i++) begin
      tick += $urandom_range(0, 20000);
      send_sample(pool_svc[p], pool_addr[p], pool_met[p], kind,
                  base + $signed($urandom_range(0, spread)) - spread / 2, thr, tick);
    end
  endtask

  // receiver stalls, long ones now and then, plain stretches too
  initial begin
    int unsigned n;
    forever begin
      stall_long = $urandom_range(0, 7) == 0;
      n = stall_long ? $urandom_range(5, 40) : $urandom_range(0, 3);
      if (n != 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int p;
    tick = 0;
    for (int i = 0; i < 8; i++) begin
      pool_svc[i]  = 16'($urandom);
      pool_addr[i] = 8'($urandom_range(1, 255));
      pool_met[i]  = 8'(i);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: address zero, extremes, both kinds, first report at tick zero
    send_sample(16'hFFFF, 8'd0, 8'hFF, 1'b1, 32'h7FFFFFFF, '1, '1);
    send_sample(16'h0000, 8'hFF, 8'h00, 1'b0, 32'h80000000, '0, '0);
    for (int i = 1; i < WinSamples; i++)
      send_sample(16'h0000, 8'hFF, 8'h00, 1'b1, (i % 2) ? 32'h7FFFFFFF : 32'h80000000,
                  '1, '0);
    for (int i = 0; i < WinSamples; i++)
      send_sample(16'hFFFF, 8'h01, 8'hFF, 1'b1, 32'h7FFFFFFF - i, '1, '1);
    drain_and_config(32'd0);

    // analog windows: medians, deadband hits and misses
    for (int r = 0; r < 6; r++)
      send_window($urandom_range(0, 3), 1'b0, $urandom, r < 3 ? 4 : 100000,
                  31'($urandom_range(0, 50)));
    // state windows
    for (int r = 0; r < 6; r++)
      send_window($urandom_range(4, 7), 1'b1, $urandom_range(0, 2), 2, '0);
    drain_and_config(32'hFFFFFFFF);
    for (int r = 0; r < 6; r++)
      send_window($urandom_range(0, 7), 1'($urandom_range(0, 1)), $urandom, 1000,
                  31'h7FFFFFFF);
    drain_and_config(32'd60000);

    // fill the table to overflow
    for (int i = 0; i < TableEntries + 4; i++)
      send_sample(16'($urandom), 8'($urandom_range(1, 255)), 8'($urandom),
                  1'($urandom), $urandom, 31'($urandom), $urandom);
    drain_and_config($urandom_range(0, 30000));

    // random: mostly windows on the pool keys (those already in table still count)
    for (int n = 0; n < 480; ) begin
      p = $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) begin
        send_sample(16'($urandom), $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom),
                    8'($urandom), 1'($urandom), $urandom, 31'($urandom), $urandom);
        n++;
      end else begin
        send_window(p, 1'($urandom_range(0, 1)), $urandom,
                    $urandom_range(0, 1) ? 8 : 2000000, 31'($urandom_range(0, 3000)));
        n += WinSamples;
      end
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- keyed_median_deadband_reporter.f -----
rtl/core/kmdr_pkg.sv
rtl/core/kmdr_ram.sv
rtl/core/keyed_median_deadband_reporter.sv
sim/kmdr_checker.sv
sim/testbench.sv
